### hdl/plist_pkg.sv
// Shared types and codes for the positional list engine.
// No dependencies; used by plist_ctrl, plist_dp and the top level.
package plist_pkg;

   // action codes carried on the request side
   localparam logic [2:0] ACT_INSERT   = 3'd0;
   localparam logic [2:0] ACT_REMOVE   = 3'd1;
   localparam logic [2:0] ACT_REPLACE  = 3'd2;
   localparam logic [2:0] ACT_RETRIEVE = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // memory read address source
   typedef enum logic [2:0] {
      RD_CNT_M1 = 3'd0,
      RD_POS    = 3'd1,
      RD_IDX_M1 = 3'd2,
      RD_IDX_P1 = 3'd3,
      RD_IDX_P2 = 3'd4
   } rd_sel_type;

   // memory write address/data source
   typedef enum logic [1:0] {
      WR_UP  = 2'd0,  // mem[idx+1] <= rdata
      WR_DN  = 2'd1,  // mem[idx]   <= rdata
      WR_VAL = 2'd2   // mem[pos]   <= value
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD   = 3'd0,
      IDX_CNT_M1 = 3'd1,
      IDX_POS    = 3'd2,
      IDX_DEC    = 3'd3,
      IDX_INC    = 3'd4
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2,
      CNT_CLR  = 2'd3
   } cnt_op_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      idx_op_type idx_op;
      cnt_op_type cnt_op;
      logic       set_status;
      logic [1:0] status_code;
      logic       capture_rd;
      logic       load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] action;
      logic       pos_gt_cnt;
      logic       pos_ge_cnt;
      logic       cnt_zero;
      logic       cnt_full;
      logic       idx_eq_pos;
      logic       idx_p1_lt_cnt;
      logic       idx_p2_lt_cnt;
      logic       out_free;
   } stat_type;

endpackage

### hdl/positional_list_engine_top.sv
// Top level of the positional list engine.
// Depends on plist_pkg, plist_ctrl and plist_dp.
//
// A bounded ordered list of up to DEPTH entries held in one on-chip memory and
// addressed by zero-based position. Each request transaction carries an action
// (insert, remove, replace, retrieve, clear), a position and a value, and
// yields exactly one response transaction with status, value read, entry
// count and empty flag. Requests are handled one at a time: req_tready is high
// only while the engine is idle, but a finished response waits in its own
// output register, so the next request is taken while it is still pending.
// Insert shifts the entries from position p up to the tail one place back,
// and remove shifts those behind p one place forward, so both take longer
// the further p lies from the count; the worst case is an insert at the head
// of a list of DEPTH-1 entries. The shift loop sets this: entries move one
// per cycle through the memory's single read and single write port.
// There is no reset sweep; memory contents are unknown until written, and
// only positions below the count are ever read.
module positional_list_engine_top #(
   parameter int DEPTH       = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [6:0] position, [38:7] entry_value, [39] zero
   input  logic [2:0]  req_tuser,   // [2:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] read_value, [38:32] entry_count, [39] is_empty
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   plist_pkg::cmd_type  cmd;
   plist_pkg::stat_type stat;

   logic [1:0]  status;
   logic [31:0] read_value;
   logic [6:0]  entry_count;
   logic        is_empty;

   plist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   plist_dp #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .action      (req_tuser),
      .position    (req_tdata[6:0]),
      .entry_value (req_tdata[38:7]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .status      (status),
      .read_value  (read_value),
      .entry_count (entry_count),
      .is_empty    (is_empty)
   );

   // response packing, highest field first
   assign rsp_tdata = {is_empty, entry_count, read_value};
   assign rsp_tuser = status;

endmodule

### hdl/plist_ctrl.sv
// Sequencer for the positional list engine: decodes the held request and
// steps the datapath through reads, shifts and the result load. Uses plist_pkg.
module plist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  plist_pkg::stat_type stat,
   output plist_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_ISSUE    = 7'b0000010,
      S_SHIFT_UP = 7'b0000100,
      S_PUT      = 7'b0001000,
      S_FETCH    = 7'b0010000,
      S_SHIFT_DN = 7'b0100000,
      S_RESULT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_RESULT;
            unique case (stat.action)
               plist_pkg::ACT_INSERT: begin
                  if (stat.pos_gt_cnt) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = plist_pkg::ST_RANGE;
                  end else if (stat.cnt_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = plist_pkg::ST_FULL;
                  end else if (stat.pos_ge_cnt) begin
                     // append at the tail: nothing to move
                     state_in = S_PUT;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = plist_pkg::RD_CNT_M1;
                     cmd.idx_op = plist_pkg::IDX_CNT_M1;
                     state_in   = S_SHIFT_UP;
                  end
               end
               plist_pkg::ACT_REMOVE: begin
                  if (stat.cnt_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = plist_pkg::ST_EMPTY;
                  end else if (stat.pos_ge_cnt) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = plist_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = plist_pkg::RD_POS;
                     cmd.idx_op = plist_pkg::IDX_POS;
                     state_in   = S_FETCH;
                  end
               end
               plist_pkg::ACT_REPLACE: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = plist_pkg::ST_RANGE;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = plist_pkg::WR_VAL;
                  end
               end
               plist_pkg::ACT_RETRIEVE: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = plist_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = plist_pkg::RD_POS;
                     cmd.idx_op = plist_pkg::IDX_POS;
                     state_in   = S_FETCH;
                  end
               end
               plist_pkg::ACT_CLEAR: begin
                  cmd.cnt_op = plist_pkg::CNT_CLR;
               end
               default: ; // unused codes: no-op, success
            endcase
         end
         S_SHIFT_UP: begin
            // rdata holds mem[idx]; move it one place back
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plist_pkg::WR_UP;
            if (stat.idx_eq_pos) begin
               state_in = S_PUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = plist_pkg::RD_IDX_M1;
               cmd.idx_op = plist_pkg::IDX_DEC;
            end
         end
         S_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plist_pkg::WR_VAL;
            cmd.cnt_op = plist_pkg::CNT_INC;
            state_in   = S_RESULT;
         end
         S_FETCH: begin
            cmd.capture_rd = 1'b1;
            state_in       = S_RESULT;
            if (stat.action == plist_pkg::ACT_REMOVE) begin
               if (stat.idx_p1_lt_cnt) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = plist_pkg::RD_IDX_P1;
                  state_in   = S_SHIFT_DN;
               end else begin
                  cmd.cnt_op = plist_pkg::CNT_DEC;
               end
            end
         end
         S_SHIFT_DN: begin
            // rdata holds mem[idx+1]; move it one place forward
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plist_pkg::WR_DN;
            if (stat.idx_p2_lt_cnt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = plist_pkg::RD_IDX_P2;
               cmd.idx_op = plist_pkg::IDX_INC;
            end else begin
               cmd.cnt_op = plist_pkg::CNT_DEC;
               state_in   = S_RESULT;
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // no memory or count change while waiting for a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!cmd.wr_en && cmd.cnt_op == plist_pkg::CNT_HOLD))
      else $error("memory or count touched while idle");

   // the result register is only loaded when it can take a transaction
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> stat.out_free)
      else $error("result overwritten while still pending");

   // a shift step always consumes data read in the previous cycle
   a_shift_fed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_UP || state_ff == S_SHIFT_DN) |-> $past(cmd.rd_en))
      else $error("shift step without a preceding read");

endmodule

### hdl/plist_dp.sv
// Datapath for the positional list engine: entry memory, count, index
// pointer, request holding and result registers. Uses plist_pkg.
module plist_dp #(
   parameter int DEPTH       = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          action,
   input  logic [6:0]          position,
   input  logic [31:0]         entry_value,
   input  plist_pkg::cmd_type  cmd,
   output plist_pkg::stat_type stat,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [1:0]          status,
   output logic [31:0]         read_value,
   output logic [6:0]          entry_count,
   output logic                is_empty
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

   logic [ENTRY_WIDTH-1:0] mem [DEPTH];
   logic [ENTRY_WIDTH-1:0] rdata_ff;

   logic [2:0]    act_ff;
   logic [6:0]    pos_ff;
   logic [31:0]   val_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [1:0]    st_ff;
   logic [31:0]   rd_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [31:0]   rsp_rd_ff;
   logic [6:0]    rsp_cnt_ff;
   logic          rsp_empty_ff;

   logic [AW-1:0]          pos_a, cnt_m1_a, rd_addr, wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic [63:0]            val_wide, rdata_wide;
   logic [CMPW-1:0]        pos_c, cnt_c, idx_c;

   assign pos_a      = AW'(pos_ff);
   assign cnt_m1_a   = AW'(cnt_ff - 1'b1);
   assign val_wide   = 64'(val_ff);
   assign rdata_wide = 64'(rdata_ff);
   assign pos_c      = CMPW'(pos_ff);
   assign cnt_c      = CMPW'(cnt_ff);
   assign idx_c      = CMPW'(idx_ff);

   always_comb begin
      case (cmd.rd_sel)
         plist_pkg::RD_CNT_M1: rd_addr = cnt_m1_a;
         plist_pkg::RD_POS:    rd_addr = pos_a;
         plist_pkg::RD_IDX_M1: rd_addr = idx_ff - 1'b1;
         plist_pkg::RD_IDX_P1: rd_addr = idx_ff + 1'b1;
         plist_pkg::RD_IDX_P2: rd_addr = idx_ff + AW'(2);
         default:              rd_addr = pos_a;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         plist_pkg::WR_UP: begin
            wr_addr = idx_ff + 1'b1;
            wr_data = rdata_ff;
         end
         plist_pkg::WR_DN: begin
            wr_addr = idx_ff;
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = pos_a;
            wr_data = ENTRY_WIDTH'(val_wide);
         end
      endcase
   end

   always_comb begin
      case (cmd.idx_op)
         plist_pkg::IDX_CNT_M1: idx_in = cnt_m1_a;
         plist_pkg::IDX_POS:    idx_in = pos_a;
         plist_pkg::IDX_DEC:    idx_in = idx_ff - 1'b1;
         plist_pkg::IDX_INC:    idx_in = idx_ff + 1'b1;
         default:               idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         plist_pkg::CNT_INC: cnt_in = cnt_ff + 1'b1;
         plist_pkg::CNT_DEC: cnt_in = cnt_ff - 1'b1;
         plist_pkg::CNT_CLR: cnt_in = '0;
         default:            cnt_in = cnt_ff;
      endcase
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // payload holding, index pointer and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= action;
         pos_ff <= position;
         val_ff <= entry_value;
         st_ff  <= plist_pkg::ST_OK;
         rd_ff  <= '0;
      end else begin
         if (cmd.set_status) begin
            st_ff <= cmd.status_code;
         end
         if (cmd.capture_rd) begin
            rd_ff <= rdata_wide[31:0];
         end
      end
      idx_ff <= idx_in;
      if (cmd.load_out) begin
         rsp_status_ff <= st_ff;
         rsp_rd_ff     <= rd_ff;
         rsp_cnt_ff    <= 7'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.action        = act_ff;
   assign stat.pos_gt_cnt    = (pos_c > cnt_c);
   assign stat.pos_ge_cnt    = (pos_c >= cnt_c);
   assign stat.cnt_zero      = (cnt_ff == '0);
   assign stat.cnt_full      = (cnt_ff == CW'(DEPTH));
   assign stat.idx_eq_pos    = (idx_ff == pos_a);
   assign stat.idx_p1_lt_cnt = ((idx_c + 1'b1) < cnt_c);
   assign stat.idx_p2_lt_cnt = ((idx_c + CMPW'(2)) < cnt_c);
   assign stat.out_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign status      = rsp_status_ff;
   assign read_value  = rsp_rd_ff;
   assign entry_count = rsp_cnt_ff;
   assign is_empty    = rsp_empty_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         (cnt_ff == $past(cnt_ff) + 1'b1 || cnt_ff == $past(cnt_ff) - 1'b1 ||
          cnt_ff == '0))
      else $error("entry count jumped");

   a_wr_in_list: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (CMPW'(wr_addr) < cnt_c || CMPW'(wr_addr) == cnt_c))
      else $error("write beyond the tail of the list");

endmodule
